FILE: rtl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// shared types, codes and widths of the fit-policy block allocator
// ----------------------------------------------------------------------------
package fpba_pkg;

  // storage defaults
  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // port field widths
  localparam int REQ_TYPE_W = 1;
  localparam int LOAD_IDX_W = 4;
  localparam int AMOUNT_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int CHOSEN_W   = 4;
  localparam int REMAIN_W   = 16;

  // configuration port
  localparam int POLICY_W   = 2;
  localparam int BCNT_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = BCNT_W'(16);

  // command queue between front and back
  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIT_POLICY  = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_LOAD  = 1'b0,
    REQ_ALLOC = 1'b1
  } req_e;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_e;

  // classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_LOAD_SKIP = 2'd1,
    OP_ALLOC     = 2'd2,
    OP_REFUSE    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED    = 2'd0,
    ST_ALLOCATED = 2'd1,
    ST_REFUSED   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_SCAN   = 2'd1,
    BK_COMMIT = 2'd2
  } back_state_e;

  typedef struct packed {
    op_e                   op;
    policy_e               policy;
    logic [BCNT_W-1:0]     count;
    logic [LOAD_IDX_W-1:0] load_idx;
    logic [AMOUNT_W-1:0]   amount;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/fit_policy_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// first, best and worst fit allocator over a table of block free sizes
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy only rises when
// the two-entry command queue is full. Every item gives exactly one result,
// shown for a single cycle with done_o high; the receiver cannot stall it.
// A load is handled in the back end as soon as it is popped. An allocate walks
// the table one block per cycle through the single read port of the free size
// memory: pop, one read per taking-part block, the last read landing, commit;
// an allocate with no block taking part is answered at the pop. Results leave
// in item order, in the cycle after the back end finishes. The table reads as
// all zeros after reset through per-block valid flags, so no clearing pass is
// needed. Write the configuration registers only while no item is in flight.
module fit_policy_block_allocator_unit import fpba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // command side
  input  logic                  start,
  output logic                  busy,
  input  logic [REQ_TYPE_W-1:0] req_type_i,
  input  logic [LOAD_IDX_W-1:0] load_index_i,
  input  logic [AMOUNT_W-1:0]   amount_i,
  // result side
  output logic                  done_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [CHOSEN_W-1:0]   chosen_block_o,
  output logic [REMAIN_W-1:0]   remaining_free_o
);

  logic        push;
  logic        pop;
  cmd_t        cmd_in;
  cmd_t        cmd_head;
  q_stat_t     q_stat;
  back_state_e bk_state;
  status_e     status;

  // front: registers, accept and classify
  fpba_front #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_i      (start),
    .full_i       (q_stat.full),
    .req_type_i   (req_type_i),
    .load_index_i (load_index_i),
    .amount_i     (amount_i),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  // queue decouples acceptance from the scan
  fpba_cmd_fifo #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .cmd_o  (cmd_head),
    .stat_o (q_stat)
  );

  // back: table, scan and result register
  fpba_back #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .stat_i           (q_stat),
    .cmd_i            (cmd_head),
    .pop_o            (pop),
    .state_o          (bk_state),
    .done_o           (done_o),
    .status_o         (status),
    .chosen_block_o   (chosen_block_o),
    .remaining_free_o (remaining_free_o)
  );

  assign busy     = q_stat.full;
  assign status_o = status;

  // a refused request carries no block and no size
  a_refused_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status == ST_REFUSED)) |-> (chosen_block_o == '0 && remaining_free_o == '0))
    else $error("refused result with nonzero fields");

  // no result is produced while the table walk is under way
  a_no_result_mid_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bk_state == BK_SCAN) |=> !done_o)
    else $error("result during scan");

  // a grant only follows a commit cycle
  a_grant_after_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status == ST_ALLOCATED)) |-> ($past(bk_state) == BK_COMMIT))
    else $error("grant without commit");

  // a full queue stays full until the back end drains an entry
  a_full_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.full && !pop) |=> q_stat.full)
    else $error("queue lost an entry");

endmodule

FILE: rtl/fpba_front.sv
// ----------------------------------------------------------------------------
// fpba_front
// configuration registers, item acceptance and classification into commands
// ----------------------------------------------------------------------------
module fpba_front import fpba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  start_i,
  input  logic                  full_i,
  input  logic [REQ_TYPE_W-1:0] req_type_i,
  input  logic [LOAD_IDX_W-1:0] load_index_i,
  input  logic [AMOUNT_W-1:0]   amount_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  logic [POLICY_W-1:0] fit_policy_q, fit_policy_d;
  logic [BCNT_W-1:0]   block_count_q, block_count_d;
  logic [BCNT_W-1:0]   count_sat;
  logic                load_ok;
  policy_e             policy;

  always_comb begin
    fit_policy_d  = fit_policy_q;
    block_count_d = block_count_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_FIT_POLICY:  fit_policy_d  = cfg_wdata_i[POLICY_W-1:0];
        REG_BLOCK_COUNT: block_count_d = cfg_wdata_i[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q  <= POL_FIRST;
      block_count_q <= BLOCK_COUNT_RST;
    end else begin
      fit_policy_q  <= fit_policy_d;
      block_count_q <= block_count_d;
    end
  end

  // unused policy code falls back to first fit
  always_comb begin
    case (fit_policy_q)
      POL_BEST:  policy = POL_BEST;
      POL_WORST: policy = POL_WORST;
      default:   policy = POL_FIRST;
    endcase
  end

  // block count saturates at the table depth
  assign count_sat = (int'(block_count_q) > NUM_BLOCKS) ? BCNT_W'(NUM_BLOCKS)
                                                         : block_count_q;
  assign load_ok   = int'(load_index_i) < NUM_BLOCKS;

  always_comb begin
    cmd_o.policy   = policy;
    cmd_o.count    = count_sat;
    cmd_o.load_idx = load_index_i;
    cmd_o.amount   = amount_i;
    if (req_e'(req_type_i) == REQ_LOAD) begin
      cmd_o.op = load_ok ? OP_LOAD : OP_LOAD_SKIP;
    end else begin
      cmd_o.op = (count_sat == '0) ? OP_REFUSE : OP_ALLOC;
    end
  end

  assign push_o = start_i & ~full_i;

endmodule

FILE: rtl/fpba_cmd_fifo.sv
// ----------------------------------------------------------------------------
// fpba_cmd_fifo
// short command queue between the front and the back end
// ----------------------------------------------------------------------------
module fpba_cmd_fifo import fpba_pkg::*; #(
  parameter int DEPTH = CMDQ_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    cmd_o,
  output q_stat_t stat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             ent_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o        = ent_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

FILE: rtl/fpba_back.sv
// ----------------------------------------------------------------------------
// fpba_back
// free size table, sequential candidate scan and result register
// ----------------------------------------------------------------------------
module fpba_back import fpba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  q_stat_t             stat_i,
  input  cmd_t                cmd_i,
  output logic                pop_o,
  output back_state_e         state_o,
  output logic                done_o,
  output status_e             status_o,
  output logic [CHOSEN_W-1:0] chosen_block_o,
  output logic [REMAIN_W-1:0] remaining_free_o
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int XW    = (IDX_W > BCNT_W) ? IDX_W : BCNT_W;
  localparam int LXW   = (IDX_W > LOAD_IDX_W) ? IDX_W : LOAD_IDX_W;
  localparam int CXW   = (IDX_W > CHOSEN_W) ? IDX_W : CHOSEN_W;
  localparam int VW    = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;

  logic [BCNT_W-1:0]    iss_q, iss_d;
  logic                 pend_q, pend_d;
  logic                 plast_q, plast_d;
  logic [IDX_W-1:0]     pidx_q, pidx_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     pick_q, pick_d;
  logic [SIZE_BITS-1:0] best_q, best_d;

  logic [SIZE_BITS-1:0] mem_q [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld_q;
  logic [SIZE_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;

  logic                 done_q, done_d;
  status_e              status_q, status_d;
  logic [CHOSEN_W-1:0]  chosen_q, chosen_d;
  logic [REMAIN_W-1:0]  remain_q, remain_d;

  logic                 we;
  logic [IDX_W-1:0]     wa, ra;
  logic [SIZE_BITS-1:0] wd;
  logic                 issue;
  logic [SIZE_BITS-1:0] sz, load_val, diff;
  logic                 cand, better, take;
  logic [XW-1:0]        iss_x;
  logic [LXW-1:0]       li_x;
  logic [CXW-1:0]       pick_x;
  logic [VW-1:0]        amt_x, diff_x, load_x;

  assign pop_o  = (state_q == BK_IDLE) && !stat_i.empty;

  assign iss_x  = XW'(iss_q);
  assign ra     = iss_x[IDX_W-1:0];
  assign li_x   = LXW'(cmd_i.load_idx);
  assign pick_x = CXW'(pick_q);

  assign amt_x    = VW'(cmd_i.amount);
  assign load_val = amt_x[SIZE_BITS-1:0];
  assign load_x   = VW'(load_val);
  assign diff_x   = VW'(best_q) - VW'(cmd_q.amount);
  assign diff     = diff_x[SIZE_BITS-1:0];

  assign issue  = (state_q == BK_SCAN) && (iss_q < cmd_q.count);
  assign sz     = rd_vld_q ? rd_data_q : '0;
  assign cand   = VW'(sz) >= VW'(cmd_q.amount);
  assign better = !found_q
               || ((cmd_q.policy == POL_BEST) && (sz < best_q))
               || ((cmd_q.policy == POL_WORST) && (sz > best_q));
  assign take   = pend_q && cand && better;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (pop_o && (cmd_i.op == OP_ALLOC)) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (pend_q && plast_q) begin
          state_d = BK_COMMIT;
        end
      end
      BK_COMMIT: state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d    = cmd_q;
    iss_d    = iss_q;
    pend_d   = issue;
    plast_d  = issue && (({1'b0, iss_q} + 1'b1) == {1'b0, cmd_q.count});
    pidx_d   = ra;
    found_d  = found_q;
    pick_d   = pick_q;
    best_d   = best_q;
    done_d   = 1'b0;
    status_d = status_q;
    chosen_d = chosen_q;
    remain_d = remain_q;
    we       = 1'b0;
    wa       = li_x[IDX_W-1:0];
    wd       = load_val;

    if (issue) begin
      iss_d = iss_q + 1'b1;
    end
    if (take) begin
      found_d = 1'b1;
      pick_d  = pidx_q;
      best_d  = sz;
    end

    case (state_q)
      BK_IDLE: begin
        if (pop_o) begin
          cmd_d   = cmd_i;
          iss_d   = '0;
          found_d = 1'b0;
          case (cmd_i.op)
            OP_LOAD: begin
              we       = 1'b1;
              done_d   = 1'b1;
              status_d = ST_LOADED;
              chosen_d = cmd_i.load_idx;
              remain_d = load_x[REMAIN_W-1:0];
            end
            OP_LOAD_SKIP: begin
              done_d   = 1'b1;
              status_d = ST_LOADED;
              chosen_d = cmd_i.load_idx;
              remain_d = '0;
            end
            OP_REFUSE: begin
              done_d   = 1'b1;
              status_d = ST_REFUSED;
              chosen_d = '0;
              remain_d = '0;
            end
            default: ;
          endcase
        end
      end
      BK_COMMIT: begin
        done_d = 1'b1;
        if (found_q) begin
          we       = 1'b1;
          wa       = pick_q;
          wd       = diff;
          status_d = ST_ALLOCATED;
          chosen_d = pick_x[CHOSEN_W-1:0];
          remain_d = REMAIN_W'(diff_x[SIZE_BITS-1:0]);
        end else begin
          status_d = ST_REFUSED;
          chosen_d = '0;
          remain_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      iss_q   <= '0;
      pend_q  <= 1'b0;
      plast_q <= 1'b0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
      plast_q <= plast_d;
      found_q <= found_d;
      done_q  <= done_d;
      if (we) begin
        vld_q[wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    pidx_q   <= pidx_d;
    pick_q   <= pick_d;
    best_q   <= best_d;
    status_q <= status_d;
    chosen_q <= chosen_d;
    remain_q <= remain_d;
  end

  // free size table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_data_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[ra];
    end
  end

  assign state_o          = state_q;
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign chosen_block_o   = chosen_q;
  assign remaining_free_o = remain_q;

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the fit-policy block allocator
// ----------------------------------------------------------------------------
// A queue of pending requests, filled phase by phase, feeds a driver that
// changes inputs on the falling edge. Every request accepted on a rising
// edge goes through a local model of the free size table. The model gives
// the grant expected for that request. A monitor compares each done_o
// strobe with the oldest expected grant. The fit policy and the block count
// are rewritten between phases, once the allocator has drained.
// ----------------------------------------------------------------------------
module tb;
  import fpba_pkg::*;

  localparam int                  RUN_LIMIT   = 500000;
  localparam int                  SETTLE_CYC  = 40;
  localparam int                  NUM_PHASES  = 14;
  // policy code with no enum member, behaves as first fit
  localparam logic [POLICY_W-1:0] POL_UNUSED  = 2'd3;

  typedef struct {
    req_e                  kind;
    logic [LOAD_IDX_W-1:0] idx;
    logic [AMOUNT_W-1:0]   amt;
  } alloc_req_t;

  typedef struct {
    status_e               status;
    logic [CHOSEN_W-1:0]   blk;
    logic [REMAIN_W-1:0]   rem;
  } grant_t;

  // dut ports; the inputs are all known from time zero
  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i      = '0;
  logic                  start            = 1'b0;
  logic                  busy;
  logic [REQ_TYPE_W-1:0] req_type_i       = '0;
  logic [LOAD_IDX_W-1:0] load_index_i     = '0;
  logic [AMOUNT_W-1:0]   amount_i         = '0;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [CHOSEN_W-1:0]   chosen_block_o;
  logic [REMAIN_W-1:0]   remaining_free_o;

  // local copy of the allocator state and its registers
  logic [REMAIN_W-1:0]   blk_free [NUM_BLOCKS_DEF];
  logic [POLICY_W-1:0]   cur_policy = POL_FIRST;
  logic [BCNT_W-1:0]     cur_count  = BLOCK_COUNT_RST;

  alloc_req_t req_q [$];    // requests not yet driven
  grant_t     grant_q [$];  // grants still owed by the allocator
  alloc_req_t cur_req;

  // driver bookkeeping, written with blocking assignments only
  bit holding     = 1'b0;   // a request is on the port with start high
  bit req_taken   = 1'b0;   // set at the rising edge of a transfer
  bit drain_first = 1'b0;   // hold the next request until all grants are in
  bit gaps_on     = 1'b0;
  int gap_left    = 0;

  int n_fail      = 0;
  int cycles      = 0;

  // phase plan: policy and block count, extremes and saturation among them
  logic [POLICY_W-1:0] ph_pol [NUM_PHASES] = '{
    POL_BEST, POL_WORST, POL_FIRST, POL_BEST, POL_WORST, POL_UNUSED, POL_WORST,
    POL_BEST, POL_FIRST, POL_BEST, POL_WORST, POL_UNUSED, POL_BEST, POL_WORST
  };
  logic [BCNT_W-1:0]   ph_cnt [NUM_PHASES] = '{
    5'd16, 5'd16, 5'd1, 5'd4, 5'd0, 5'd9, 5'd31,
    5'd17, 5'd8, 5'd16, 5'd16, 5'd16, 5'd2, 5'd16
  };

  fit_policy_block_allocator_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .load_index_i     (load_index_i),
    .amount_i         (amount_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .chosen_block_o   (chosen_block_o),
    .remaining_free_o (remaining_free_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // expected grant for one request; updates the local table
  function automatic grant_t grant_predict(req_e kind, logic [LOAD_IDX_W-1:0] idx,
                                           logic [AMOUNT_W-1:0] amt);
    grant_t g;
    int     lim;
    bit     hit;
    int     pick;
    g = '{ST_LOADED, idx, '0};
    if (kind == REQ_LOAD) begin
      // the index is always inside the table at this size
      blk_free[idx] = amt;
      g.rem = amt;
      return g;
    end
    // block counts above the table size saturate
    lim  = (cur_count > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(cur_count);
    hit  = 1'b0;
    pick = 0;
    for (int j = 0; j < lim; j++) begin
      if (blk_free[j] >= amt) begin
        if (!hit) begin
          hit  = 1'b1;
          pick = j;
          // first fit and the unused code stop at the lowest candidate
          if (cur_policy != POL_BEST && cur_policy != POL_WORST) break;
        end else if (cur_policy == POL_BEST && blk_free[j] < blk_free[pick]) begin
          pick = j;
        end else if (cur_policy == POL_WORST && blk_free[j] > blk_free[pick]) begin
          pick = j;
        end
      end
    end
    if (!hit) begin
      g = '{ST_REFUSED, '0, '0};
      return g;
    end
    blk_free[pick] = blk_free[pick] - amt;
    g = '{ST_ALLOCATED, CHOSEN_W'(pick), blk_free[pick]};
    return g;
  endfunction

  task automatic push_req(req_e kind, logic [LOAD_IDX_W-1:0] idx, logic [AMOUNT_W-1:0] amt);
    alloc_req_t r;
    r = '{kind, idx, amt};
    req_q.push_back(r);
  endtask

  // one-cycle register write; the local copy follows right away
  task automatic write_reg(cfg_reg_e addr, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (addr == REG_FIT_POLICY) cur_policy = val[POLICY_W-1:0];
    else cur_count = val[BCNT_W-1:0];
  endtask

  // wait until nothing is queued, on the port or owed
  task automatic wait_drained();
    while (req_q.size() != 0 || holding || grant_q.size() != 0) @(negedge clk_i);
  endtask

  // driver: one request per transfer, random gaps between transfers when gaps are on
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_taken) begin
        req_taken   = 1'b0;
        holding     = 1'b0;
        gap_left    = gaps_on ? $urandom_range(0, 13) : 0;
        // now and then let the allocator empty out completely
        drain_first = ($urandom_range(0, 29) == 0);
      end
      if (!holding) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (!(drain_first && grant_q.size() != 0) && req_q.size() != 0) begin
          cur_req     = req_q.pop_front();
          holding     = 1'b1;
          drain_first = 1'b0;
        end
      end
      start        <= holding;
      req_type_i   <= cur_req.kind;
      load_index_i <= cur_req.idx;
      amount_i     <= cur_req.amt;
    end
  end

  // monitor and transfer capture on the rising edge
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d grants still owed", cycles, grant_q.size());
      $display("fit_policy_block_allocator_unit test failed");
      $finish;
    end else if (rst_ni) begin
      if (done_o) begin
        if (grant_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected result: status %0d block %0d free %0d",
                     status_o, chosen_block_o, remaining_free_o);
        end else begin
          grant_t want;
          want = grant_q.pop_front();
          if (status_o != want.status || chosen_block_o != want.blk ||
              remaining_free_o != want.rem) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch: exp status %0d block %0d free %0d, got %0d %0d %0d",
                       want.status, want.blk, want.rem,
                       status_o, chosen_block_o, remaining_free_o);
          end
        end
      end
      // a new request can only give its result on a later edge
      if (start && !busy) begin
        grant_q.push_back(grant_predict(req_e'(req_type_i), load_index_i, amount_i));
        req_taken = 1'b1;
      end
    end
  end

  initial begin
    int n_items;
    int roll;
    alloc_req_t r;
    for (int i = 0; i < NUM_BLOCKS_DEF; i++) blk_free[i] = '0;
    ph_cnt[10] = BCNT_W'($urandom_range(1, 16));
    ph_cnt[13] = BCNT_W'($urandom_range(1, 16));
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset setting: first fit over all sixteen blocks
    push_req(REQ_ALLOC, 4'd0, 16'd0);       // zero request on an empty table
    push_req(REQ_ALLOC, 4'd0, 16'd1);       // nothing fits
    push_req(REQ_LOAD, 4'd0, 16'hFFFF);
    push_req(REQ_LOAD, 4'd15, 16'd100);
    push_req(REQ_LOAD, 4'd5, 16'd300);
    push_req(REQ_LOAD, 4'd7, 16'd300);      // tie with block 5
    push_req(REQ_LOAD, 4'd3, 16'd50);
    push_req(REQ_LOAD, 4'd10, 16'd0);
    push_req(REQ_ALLOC, 4'd15, 16'hFFFF);   // largest request, exact fit
    push_req(REQ_ALLOC, 4'd0, 16'hFFFF);    // request too large
    push_req(REQ_ALLOC, 4'd9, 16'd0);
    push_req(REQ_ALLOC, 4'd0, 16'd40);
    push_req(REQ_ALLOC, 4'd0, 16'd300);
    push_req(REQ_ALLOC, 4'd0, 16'd300);
    push_req(REQ_ALLOC, 4'd0, 16'd101);
    push_req(REQ_ALLOC, 4'd0, 16'd100);
    push_req(REQ_LOAD, 4'd9, 16'hAAAA);
    push_req(REQ_LOAD, 4'd6, 16'h5555);
    push_req(REQ_ALLOC, 4'd0, 16'h5555);
    push_req(REQ_ALLOC, 4'd0, 16'd1);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      // an allocate walks at most the whole table, give it time to settle
      repeat (24) @(negedge clk_i);
      // junk in the unused data bits of the policy write
      write_reg(REG_FIT_POLICY, CFG_DATA_W'(($urandom_range(0, 7) << POLICY_W) | ph_pol[ph]));
      write_reg(REG_BLOCK_COUNT, ph_cnt[ph]);
      gaps_on = (ph % 3 != 0);
      n_items = (ph_cnt[ph] == 0) ? 30 : 68;
      for (int k = 0; k < n_items; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // noise: anything the fields allow
          r.kind = req_e'($urandom_range(0, 1));
          r.idx  = LOAD_IDX_W'($urandom_range(0, 15));
          r.amt  = AMOUNT_W'($urandom_range(0, 65535));
        end else if (roll < 45) begin
          // loads on a coarse grid so that equal sizes are common
          r.kind = REQ_LOAD;
          r.idx  = LOAD_IDX_W'($urandom_range(0, 15));
          r.amt  = AMOUNT_W'($urandom_range(0, 12) * 25);
          if ($urandom_range(0, 3) == 0) r.amt = r.amt + AMOUNT_W'($urandom_range(0, 24));
          if ($urandom_range(0, 19) == 0) r.amt = AMOUNT_W'($urandom_range(65000, 65535));
        end else begin
          // allocates sized against the loaded range, some refused
          r.kind = REQ_ALLOC;
          r.idx  = LOAD_IDX_W'($urandom_range(0, 15));
          r.amt  = ($urandom_range(0, 9) == 0) ? '0 : AMOUNT_W'($urandom_range(1, 320));
          if ($urandom_range(0, 29) == 0) r.amt = AMOUNT_W'($urandom_range(60000, 65535));
        end
        req_q.push_back(r);
      end
    end

    wait_drained();
    repeat (SETTLE_CYC) @(negedge clk_i);
    n_fail += grant_q.size();
    if (n_fail == 0)
      $display("fit_policy_block_allocator_unit test passed");
    else
      $display("fit_policy_block_allocator_unit test failed");
    $finish;
  end

endmodule
